@@ src/srpd_pkg.sv @@
package srpd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_KEY    = 3'd1,
    PH_SIZE   = 3'd2,
    PH_TCOUNT = 3'd3,
    PH_CCOUNT = 3'd4,
    PH_RGB    = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  // colour key length in bytes
  localparam int unsigned KeyBytes = 3;
  // bytes of a run header (two 16-bit counts) and of one rgb triple
  localparam int unsigned RunHdrBytes = 4;
  localparam int unsigned RgbBytes    = 3;

  // result queue depth, a power of two
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  start_index;
    logic [10:0] run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        opaque;
    logic        sprite_done;
    logic        corrupt;
  } out_beat_t;

endpackage

@@ src/sprite_rle_pixel_decoder.sv @@
// sprite run-length pixel decoder
//
// input channel: one record byte per beat (in_valid_i / in_stall_o). a beat with
// record_start set opens a new record: three colour-key bytes, a little-endian
// 16-bit data size, then runs of (transparent count, coloured count, rgb triples).
// output channel: write descriptors (out_valid_o / out_stall_i), at most two per
// input byte: a transparent fill, an opaque pixel, the closing fill with
// sprite_done, or a single corrupt descriptor when a run overruns the sprite.
//
// throughput: one byte per cycle. each byte is registered, decoded by
// combinational logic and its descriptors are written into a 4-entry queue;
// the decode step waits only while the queue has fewer than two free entries.
// a byte's descriptors are written into the queue when the registered byte is
// decoded, and are offered on out_valid_o behind any earlier ones; a nearly
// full queue holds the byte in the input register until two entries are free.
//
// reset clears the parser to idle and empties the queue; bytes that arrive
// before a record start are dropped. when the receiver stalls, the head
// descriptor holds steady and the queue fills; once it is nearly full the
// input channel stalls as well, so nothing is lost.
module sprite_rle_pixel_decoder #(
  parameter int unsigned SPRITE_SIDE = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srpd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srpd_pkg::out_beat_t out_data_o
);

  localparam int unsigned PixTotal = SPRITE_SIDE * SPRITE_SIDE;
  localparam int unsigned WpW      = $clog2(PixTotal + 1);
  localparam int unsigned QPtrW    = $clog2(srpd_pkg::QueueDepth);
  localparam int unsigned QCntW    = $clog2(srpd_pkg::QueueDepth + 1);

  localparam logic [WpW-1:0] PixTotalW = WpW'(PixTotal);

  // input register
  logic               in_valid_q;
  srpd_pkg::in_beat_t in_beat_q;
  logic               adv;

  // parser state
  srpd_pkg::phase_e phase_q, phase_d;
  logic [1:0]       bif_q, bif_d;
  logic [15:0]      data_size_q, data_size_d;
  logic [16:0]      bc_q, bc_d;
  logic [15:0]      tc_q, tc_d;
  logic [15:0]      cl_q, cl_d;
  logic [WpW-1:0]   wp_q, wp_d;
  logic [7:0]       low_q, low_d;
  logic [7:0]       red_q, red_d;
  logic [7:0]       green_q, green_d;

  // result queue
  srpd_pkg::out_beat_t q_mem [srpd_pkg::QueueDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]    cnt_q;
  logic                pop;

  // descriptors produced by the current byte
  srpd_pkg::out_beat_t res_a, res_b, res0, res1;
  logic                has_a, has_b;
  logic [1:0]          n_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_beat_q <= in_data_i;
    end
  end

  // decode only when the queue can take two descriptors
  assign adv        = in_valid_q && (cnt_q <= QCntW'(srpd_pkg::QueueDepth - 2));
  assign in_stall_o = in_valid_q && !adv;

  function automatic srpd_pkg::out_beat_t closing_fill(input logic [WpW-1:0] w);
    srpd_pkg::out_beat_t r;
    logic [31:0]         s32;
    logic [31:0]         rest32;
    r             = '0;
    s32           = 32'(w);
    rest32        = 32'(PixTotalW - w);
    r.start_index = s32[9:0];
    r.run_length  = rest32[10:0];
    r.sprite_done = 1'b1;
    return r;
  endfunction

  always_comb begin
    logic [15:0]    word;
    logic [1:0]     bif_inc;
    logic [17:0]    reach;
    logic [16:0]    bc_new;
    logic [WpW-1:0] wp_mid;
    logic [15:0]    cl_new;
    logic [31:0]    s32;

    phase_d     = phase_q;
    bif_d       = bif_q;
    data_size_d = data_size_q;
    bc_d        = bc_q;
    tc_d        = tc_q;
    cl_d        = cl_q;
    wp_d        = wp_q;
    low_d       = low_q;
    red_d       = red_q;
    green_d     = green_q;
    res_a       = '0;
    res_b       = '0;
    has_a       = 1'b0;
    has_b       = 1'b0;

    word    = {in_beat_q.data_byte, low_q};
    bif_inc = bif_q + 2'd1;
    reach   = 18'(wp_q) + 18'(tc_q) + 18'(word);
    bc_new  = '0;
    wp_mid  = wp_q;
    cl_new  = cl_q - 16'd1;
    s32     = 32'(wp_q);

    if (adv) begin
      if (in_beat_q.record_start) begin
        // restart: drop any record in progress
        phase_d     = srpd_pkg::PH_KEY;
        bif_d       = 2'd1;
        data_size_d = '0;
        bc_d        = '0;
        tc_d        = '0;
        cl_d        = '0;
        wp_d        = '0;
        low_d       = '0;
        red_d       = '0;
        green_d     = '0;
      end else begin
        case (phase_q)
          srpd_pkg::PH_KEY: begin
            if (bif_inc == 2'(srpd_pkg::KeyBytes)) begin
              bif_d   = 2'd0;
              phase_d = srpd_pkg::PH_SIZE;
            end else begin
              bif_d = bif_inc;
            end
          end
          srpd_pkg::PH_SIZE, srpd_pkg::PH_TCOUNT, srpd_pkg::PH_CCOUNT: begin
            if (bif_q == 2'd0) begin
              low_d = in_beat_q.data_byte;
              bif_d = 2'd1;
            end else begin
              bif_d = 2'd0;
              if (phase_q == srpd_pkg::PH_SIZE) begin
                data_size_d = word;
                if (word == 16'd0) begin
                  has_b   = 1'b1;
                  res_b   = closing_fill(wp_q);
                  wp_d    = PixTotalW;
                  phase_d = srpd_pkg::PH_DONE;
                end else begin
                  phase_d = srpd_pkg::PH_TCOUNT;
                end
              end else if (phase_q == srpd_pkg::PH_TCOUNT) begin
                tc_d    = word;
                phase_d = srpd_pkg::PH_CCOUNT;
              end else if (reach > 18'(PixTotal)) begin
                // run overruns the sprite: flag and abandon the record
                has_a               = 1'b1;
                res_a.start_index   = s32[9:0];
                res_a.sprite_done   = 1'b1;
                res_a.corrupt       = 1'b1;
                phase_d             = srpd_pkg::PH_DONE;
              end else begin
                bc_new = bc_q + 17'(srpd_pkg::RunHdrBytes);
                bc_d   = bc_new;
                if (tc_q != 16'd0) begin
                  has_a             = 1'b1;
                  res_a.start_index = s32[9:0];
                  res_a.run_length  = tc_q[10:0];
                  wp_mid            = wp_q + WpW'(tc_q);
                end
                wp_d = wp_mid;
                if (word != 16'd0) begin
                  cl_d    = word;
                  phase_d = srpd_pkg::PH_RGB;
                end else if (bc_new >= {1'b0, data_size_q}) begin
                  has_b   = 1'b1;
                  res_b   = closing_fill(wp_mid);
                  wp_d    = PixTotalW;
                  phase_d = srpd_pkg::PH_DONE;
                end else begin
                  phase_d = srpd_pkg::PH_TCOUNT;
                end
              end
            end
          end
          srpd_pkg::PH_RGB: begin
            if (bif_q == 2'd0) begin
              red_d = in_beat_q.data_byte;
              bif_d = 2'd1;
            end else if (bif_q == 2'd1) begin
              green_d = in_beat_q.data_byte;
              bif_d   = 2'd2;
            end else begin
              bif_d             = 2'd0;
              has_a             = 1'b1;
              res_a.start_index = s32[9:0];
              res_a.run_length  = 11'd1;
              res_a.red         = red_q;
              res_a.green       = green_q;
              res_a.blue        = in_beat_q.data_byte;
              res_a.opaque      = 1'b1;
              wp_mid            = wp_q + WpW'(1);
              wp_d              = wp_mid;
              bc_new            = bc_q + 17'(srpd_pkg::RgbBytes);
              bc_d              = bc_new;
              cl_d              = cl_new;
              if (cl_new == 16'd0) begin
                if (bc_new >= {1'b0, data_size_q}) begin
                  has_b   = 1'b1;
                  res_b   = closing_fill(wp_mid);
                  wp_d    = PixTotalW;
                  phase_d = srpd_pkg::PH_DONE;
                end else begin
                  phase_d = srpd_pkg::PH_TCOUNT;
                end
              end
            end
          end
          default: begin
            // idle or finished: stray bytes are ignored
          end
        endcase
      end
    end
  end

  // pack the produced descriptors into consecutive queue slots
  always_comb begin
    if (has_a) begin
      res0  = res_a;
      res1  = res_b;
      n_res = has_b ? 2'd2 : 2'd1;
    end else begin
      res0  = res_b;
      res1  = res_b;
      n_res = has_b ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= srpd_pkg::PH_IDLE;
      bif_q       <= '0;
      data_size_q <= '0;
      bc_q        <= '0;
      tc_q        <= '0;
      cl_q        <= '0;
      wp_q        <= '0;
      low_q       <= '0;
      red_q       <= '0;
      green_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      bif_q       <= bif_d;
      data_size_q <= data_size_d;
      bc_q        <= bc_d;
      tc_q        <= tc_d;
      cl_q        <= cl_d;
      wp_q        <= wp_d;
      low_q       <= low_d;
      red_q       <= red_d;
      green_q     <= green_d;
    end
  end

  // result queue
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      q_mem[wr_ptr_q + QPtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(n_res) - QCntW'(pop);
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(srpd_pkg::QueueDepth))
    else $error("result queue overflow");

  // a beat that leaves with nothing pushed shrinks the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (n_res == 2'd0) |=> cnt_q == $past(cnt_q) - QCntW'(1))
    else $error("queue count mismatch on pop");

  // corrupt descriptors close the sprite and write nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.corrupt |->
      out_data_o.sprite_done && (out_data_o.run_length == 11'd0) && !out_data_o.opaque)
    else $error("malformed corrupt descriptor");

  // opaque descriptors are single pixels and never close the sprite
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.opaque |->
      (out_data_o.run_length == 11'd1) && !out_data_o.sprite_done)
    else $error("malformed opaque descriptor");

endmodule
